// ===== sv/afc_pkg.sv =====
// Shared types and constants for the box-versus-frustum classifier.
// No dependencies; imported by the plane evaluator and the top level.
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

	localparam int PLANE_REGS     = 6;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int NORM_BITS      = 14;
	localparam int OFFSET_BITS    = 22;

	typedef struct packed {
		logic signed [OFFSET_BITS-1:0] offset;
		logic signed [NORM_BITS-1:0]   nz;
		logic signed [NORM_BITS-1:0]   ny;
		logic signed [NORM_BITS-1:0]   nx;
	} plane_t;

	typedef enum logic [1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	typedef struct packed {
		logic outside;
		logic crossing;
	} plane_hit_t;

endpackage

`default_nettype wire

// ===== sv/afc_box_if.sv =====
// Input channel carrying one box item: min and max corners.
// Depends on nothing; COORD_BITS sets the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface afc_box_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] min_x;
	logic signed [COORD_BITS-1:0] min_y;
	logic signed [COORD_BITS-1:0] min_z;
	logic signed [COORD_BITS-1:0] max_x;
	logic signed [COORD_BITS-1:0] max_y;
	logic signed [COORD_BITS-1:0] max_z;

	modport source (
		output valid, min_x, min_y, min_z, max_x, max_y, max_z,
		input  ready
	);
	modport sink (
		input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/afc_result_if.sv =====
// Output channel carrying one classification item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface afc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic       bounds_invalid;

	modport source (
		output valid, verdict, bounds_invalid,
		input  ready
	);
	modport sink (
		input  valid, verdict, bounds_invalid,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/aabb_frustum_classifier_core.sv =====
// Top level of the box-versus-frustum classifier: plane registers, input
// register, per-plane evaluators and result register. Uses afc_pkg,
// afc_box_if, afc_result_if and afc_plane_eval.
//
//   channel   dir   handshake      payload
//   box       in    valid/ready    min_x min_y min_z max_x max_y max_z
//   result    out   valid/ready    verdict bounds_invalid
//   cfg       in    cfg_we         cfg_index cfg_data (write only)
//
// Each item passes through the input register and then the result
// register; one item per cycle sustained while the result side is ready.
// The plane distances are all computed between those two registers.
// Reset clears the plane registers and both valid flags; no clearing pass.
// A stalled result holds in place; the input register still fills behind it.
`timescale 1ns / 1ps
`default_nettype none

module aabb_frustum_classifier_core
	import afc_pkg::*;
#(
	parameter int NUM_PLANES = 6,
	parameter int COORD_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	afc_box_if.sink                   box,
	afc_result_if.source              result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int EVAL_PLANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

	plane_t plane_q [PLANE_REGS];

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [COORD_BITS-1:0] hi_x_s1, hi_y_s1, hi_z_s1;

	logic     valid_s2;
	verdict_t verdict_s2;
	logic     invalid_s2;

	logic       adv_s2;
	logic       load_s1;
	plane_hit_t hit [EVAL_PLANES];
	logic       any_outside, any_crossing, invalid;
	verdict_t   verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_REGS; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < PLANE_REGS)) begin
			plane_q[cfg_index] <= plane_t'(cfg_data);
		end
	end

	assign adv_s2    = !valid_s2 || result.ready;
	assign box.ready = !valid_s1 || adv_s2;
	assign load_s1   = box.valid && box.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (box.ready) begin
			valid_s1 <= box.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			lo_x_s1 <= box.min_x;
			lo_y_s1 <= box.min_y;
			lo_z_s1 <= box.min_z;
			hi_x_s1 <= box.max_x;
			hi_y_s1 <= box.max_y;
			hi_z_s1 <= box.max_z;
		end
	end

	for (genvar p = 0; p < EVAL_PLANES; p++) begin : g_plane
		afc_plane_eval #(
			.COORD_BITS(COORD_BITS)
		) u_eval (
			.plane(plane_q[p]),
			.lo_x (lo_x_s1),
			.lo_y (lo_y_s1),
			.lo_z (lo_z_s1),
			.hi_x (hi_x_s1),
			.hi_y (hi_y_s1),
			.hi_z (hi_z_s1),
			.hit  (hit[p])
		);
	end

	always_comb begin
		any_outside  = 1'b0;
		any_crossing = 1'b0;
		for (int p = 0; p < EVAL_PLANES; p++) begin
			any_outside  = any_outside | hit[p].outside;
			any_crossing = any_crossing | hit[p].crossing;
		end
		invalid = (lo_x_s1 > hi_x_s1) || (lo_y_s1 > hi_y_s1) || (lo_z_s1 > hi_z_s1);
		if (invalid) begin
			verdict = VERDICT_INSIDE;
		end else if (any_outside) begin
			verdict = VERDICT_OUTSIDE;
		end else if (any_crossing) begin
			verdict = VERDICT_INTERSECT;
		end else begin
			verdict = VERDICT_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			verdict_s2 <= verdict;
			invalid_s2 <= invalid;
		end
	end

	assign result.valid          = valid_s2;
	assign result.verdict        = verdict_s2;
	assign result.bounds_invalid = invalid_s2;

endmodule

`default_nettype wire

// ===== sv/afc_plane_eval.sv =====
// Evaluates one plane against a box: picks the positive and negative
// vertices and tests the sign of both exact distances. Uses afc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afc_plane_eval
	import afc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  plane_t                       plane,
	input  logic signed [COORD_BITS-1:0] lo_x,
	input  logic signed [COORD_BITS-1:0] lo_y,
	input  logic signed [COORD_BITS-1:0] lo_z,
	input  logic signed [COORD_BITS-1:0] hi_x,
	input  logic signed [COORD_BITS-1:0] hi_y,
	input  logic signed [COORD_BITS-1:0] hi_z,
	output plane_hit_t                   hit
);

	localparam int DIST_BITS = NORM_BITS + COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
	logic signed [COORD_BITS-1:0] neg_x, neg_y, neg_z;
	logic signed [DIST_BITS-1:0]  dist_pos, dist_neg;

	always_comb begin
		pos_x = plane.nx[NORM_BITS-1] ? lo_x : hi_x;
		pos_y = plane.ny[NORM_BITS-1] ? lo_y : hi_y;
		pos_z = plane.nz[NORM_BITS-1] ? lo_z : hi_z;
		neg_x = plane.nx[NORM_BITS-1] ? hi_x : lo_x;
		neg_y = plane.ny[NORM_BITS-1] ? hi_y : lo_y;
		neg_z = plane.nz[NORM_BITS-1] ? hi_z : lo_z;

		dist_pos = DIST_BITS'(plane.nx) * DIST_BITS'(pos_x)
			+ DIST_BITS'(plane.ny) * DIST_BITS'(pos_y)
			+ DIST_BITS'(plane.nz) * DIST_BITS'(pos_z)
			+ DIST_BITS'(plane.offset);
		dist_neg = DIST_BITS'(plane.nx) * DIST_BITS'(neg_x)
			+ DIST_BITS'(plane.ny) * DIST_BITS'(neg_y)
			+ DIST_BITS'(plane.nz) * DIST_BITS'(neg_z)
			+ DIST_BITS'(plane.offset);

		hit.outside  = dist_pos[DIST_BITS-1];
		hit.crossing = dist_neg[DIST_BITS-1];
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for aabb_frustum_classifier_core: box items against six plane registers.
// Uses afc_pkg, afc_box_if and afc_result_if from the RTL. A directed table runs first,
// then random phases checked by an in-bench classifier.
`timescale 1ns / 1ps

module tb;
	import afc_pkg::*;

	localparam int COORD_W       = 16;
	localparam int PLANE_CNT     = 6;
	localparam int RAND_PHASES   = 13;
	localparam int PHASE_ITEMS   = 150;
	localparam int MAX_GAP       = 5;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 1000;
	localparam int REPORT_MAX    = 10;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR,
		REG_SPARE_LO, REG_SPARE_HI
	} plane_reg_e;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t max_z, max_y, max_x, min_z, min_y, min_x;
	} box_t;

	typedef struct packed {
		verdict_t verdict;
		logic     bounds_invalid;
	} verdict_rec_t;

	typedef struct packed {
		logic                     is_cfg;
		plane_reg_e               idx;
		logic [CFG_DATA_BITS-1:0] data;
		box_t                     b;
		logic                     typed;
		verdict_rec_t             want;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	afc_box_if #(.COORD_BITS(COORD_W)) box_ch ();
	afc_result_if                      res_ch ();

	aabb_frustum_classifier_core #(
		.NUM_PLANES(PLANE_CNT),
		.COORD_BITS(COORD_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.box      (box_ch),
		.result   (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	plane_t       plane_q [PLANE_REGS];
	verdict_rec_t verdict_q [$];
	stim_row_t    dir_rows [$];
	int           mismatches = 0;
	int           idle_cycles = 0;
	bit           full_rate = 1'b0;

	always #4 clk = ~clk;

	function automatic plane_t mk_plane(int nx, int ny, int nz, int off);
		plane_t p;
		p.nx     = nx[NORM_BITS-1:0];
		p.ny     = ny[NORM_BITS-1:0];
		p.nz     = nz[NORM_BITS-1:0];
		p.offset = off[OFFSET_BITS-1:0];
		return p;
	endfunction

	function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
		box_t b;
		b.min_x = lx[COORD_W-1:0];
		b.min_y = ly[COORD_W-1:0];
		b.min_z = lz[COORD_W-1:0];
		b.max_x = hx[COORD_W-1:0];
		b.max_y = hy[COORD_W-1:0];
		b.max_z = hz[COORD_W-1:0];
		return b;
	endfunction

	function automatic verdict_rec_t classify_box(box_t b);
		verdict_rec_t                r;
		coord_t                      lo [3];
		coord_t                      hi [3];
		logic signed [NORM_BITS-1:0] nrm [3];
		plane_t                      pl;
		longint                      d_pos;
		longint                      d_neg;
		logic                        cull;
		logic                        straddle;
		lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
		hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
		r.verdict        = VERDICT_INSIDE;
		r.bounds_invalid = (lo[0] > hi[0]) || (lo[1] > hi[1]) || (lo[2] > hi[2]);
		if (r.bounds_invalid) begin
			return r;
		end
		cull     = 1'b0;
		straddle = 1'b0;
		for (int i = 0; i < PLANE_CNT; i++) begin
			pl     = plane_q[i];
			nrm[0] = pl.nx;
			nrm[1] = pl.ny;
			nrm[2] = pl.nz;
			d_pos  = longint'(pl.offset);
			d_neg  = d_pos;
			for (int a = 0; a < 3; a++) begin
				if (nrm[a] < 0) begin
					d_pos += longint'(nrm[a]) * longint'(lo[a]);
					d_neg += longint'(nrm[a]) * longint'(hi[a]);
				end else begin
					d_pos += longint'(nrm[a]) * longint'(hi[a]);
					d_neg += longint'(nrm[a]) * longint'(lo[a]);
				end
			end
			if (d_pos < 0) begin
				cull = 1'b1;
			end else if (d_neg < 0) begin
				straddle = 1'b1;
			end
		end
		if (cull) begin
			r.verdict = VERDICT_OUTSIDE;
		end else if (straddle) begin
			r.verdict = VERDICT_INTERSECT;
		end
		return r;
	endfunction

	function automatic coord_t rand_coord();
		logic [31:0] v;
		v = $urandom;
		return v[COORD_W-1:0];
	endfunction

	function automatic plane_t rand_plane();
		int pick;
		int mag [3];
		int off;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return '0;
		end
		if (pick == 1) begin
			return plane_t'({$urandom, $urandom});
		end
		for (int a = 0; a < 3; a++) begin
			mag[a] = $urandom_range(0, 128);
			if ($urandom_range(0, 1) == 1) begin
				mag[a] = -mag[a];
			end
		end
		off = $urandom_range(0, (1 << (OFFSET_BITS - 1)) - 1);
		if ($urandom_range(0, 3) == 0) begin
			off = -off - 1;
		end
		return mk_plane(mag[0], mag[1], mag[2], off);
	endfunction

	function automatic box_t rand_box();
		coord_t lo [3];
		coord_t hi [3];
		coord_t a;
		coord_t b;
		int     kind;
		int     ax;
		int     c;
		box_t   bx;
		kind = $urandom_range(0, 19);
		for (int i = 0; i < 3; i++) begin
			if (kind <= 5) begin
				a = rand_coord();
				b = rand_coord();
				if (kind == 5 || a <= b) begin
					lo[i] = a;
					hi[i] = b;
				end else begin
					lo[i] = b;
					hi[i] = a;
				end
			end else begin
				c     = $urandom_range(0, 4096) - 2048;
				lo[i] = coord_t'(c - $urandom_range(0, 512));
				hi[i] = coord_t'(c + $urandom_range(0, 512));
			end
		end
		if (kind == 0) begin
			ax = $urandom_range(0, 2);
			do begin
				a = rand_coord();
				b = rand_coord();
			end while (a == b);
			lo[ax] = (a > b) ? a : b;
			hi[ax] = (a > b) ? b : a;
		end
		bx.min_x = lo[0]; bx.min_y = lo[1]; bx.min_z = lo[2];
		bx.max_x = hi[0]; bx.max_y = hi[1]; bx.max_z = hi[2];
		return bx;
	endfunction

	function automatic void add_cfg(plane_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
		stim_row_t row;
		row        = '0;
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_box(box_t b, logic typed, verdict_t v, logic inv);
		stim_row_t row;
		row                     = '0;
		row.b                   = b;
		row.typed               = typed;
		row.want.verdict        = v;
		row.want.bounds_invalid = inv;
		dir_rows.push_back(row);
	endfunction

	task automatic note_mismatch(string what, verdict_rec_t want, verdict_rec_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t %s: expected verdict %0d invalid %0b, got verdict %0d invalid %0b",
				$realtime, what, want.verdict, want.bounds_invalid, got.verdict,
				got.bounds_invalid);
		end
	endtask

	task automatic cfg_write(plane_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx < PLANE_REGS) begin
			plane_q[idx] = data;
		end
	endtask

	task automatic settle();
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_box(box_t b, logic typed, verdict_rec_t want);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, MAX_GAP);
		cfg_we <= 1'b0;
		if (gap > 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.min_x <= b.min_x;
		box_ch.min_y <= b.min_y;
		box_ch.min_z <= b.min_z;
		box_ch.max_x <= b.max_x;
		box_ch.max_y <= b.max_y;
		box_ch.max_z <= b.max_z;
		do @(posedge clk); while (!(box_ch.valid && box_ch.ready));
		verdict_q.push_back(typed ? want : classify_box(b));
	endtask

	// result side: random stall before each item
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = full_rate ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	always @(posedge clk) begin
		verdict_rec_t want;
		verdict_rec_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.verdict        = verdict_t'(res_ch.verdict);
			got.bounds_invalid = res_ch.bounds_invalid;
			if (verdict_q.size() == 0) begin
				note_mismatch("unexpected item", '0, got);
			end else begin
				want = verdict_q.pop_front();
				if (got.verdict !== want.verdict
						|| got.bounds_invalid !== want.bounds_invalid) begin
					note_mismatch("mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready)
				|| cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("aabb_frustum_classifier_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		bit        prev_cfg;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		box_ch.valid <= 1'b0;
		box_ch.min_x <= '0;
		box_ch.min_y <= '0;
		box_ch.min_z <= '0;
		box_ch.max_x <= '0;
		box_ch.max_y <= '0;
		box_ch.max_z <= '0;
		foreach (plane_q[i]) begin
			plane_q[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1, VERDICT_INSIDE, 0);
		add_box(mk_box(0, 0, 0, 0, 0, 0), 1, VERDICT_INSIDE, 0);
		add_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768), 1,
			VERDICT_INSIDE, 0);
		add_box(mk_box(32767, 0, 0, -32768, 0, 0), 1, VERDICT_INSIDE, 1);
		add_box(mk_box(0, 1, 0, 0, 0, 0), 1, VERDICT_INSIDE, 1);
		add_box(mk_box(0, 0, 32767, 0, 0, 32766), 1, VERDICT_INSIDE, 1);
		add_cfg(REG_LEFT, mk_plane(0, 0, 0, -1));
		add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1, VERDICT_OUTSIDE, 0);
		add_box(mk_box(5, 0, 0, 4, 0, 0), 1, VERDICT_INSIDE, 1);
		add_cfg(REG_LEFT, '0);
		add_cfg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(REG_SPARE_HI, mk_plane(0, 0, 0, -1));
		add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1, VERDICT_INSIDE, 0);
		add_cfg(REG_FAR, mk_plane(4096, 0, 0, 0));
		add_box(mk_box(-10, 0, 0, 10, 0, 0), 1, VERDICT_INTERSECT, 0);
		add_box(mk_box(0, 0, 0, 5, 0, 0), 1, VERDICT_INSIDE, 0);
		add_box(mk_box(-5, 0, 0, -1, 0, 0), 1, VERDICT_OUTSIDE, 0);
		add_cfg(REG_NEAR, mk_plane(-8192, -8192, -8192, (1 << (OFFSET_BITS - 1)) - 1));
		add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 0, VERDICT_INSIDE, 0);
		add_cfg(REG_TOP, mk_plane(8191, 8191, 8191, -(1 << (OFFSET_BITS - 1))));
		add_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 0, VERDICT_INSIDE, 0);
		add_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768), 0,
			VERDICT_INSIDE, 0);
		add_cfg(REG_BOTTOM, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(REG_RIGHT, mk_plane(0, -1, 0, 0));
		add_box(mk_box(-100, -200, -300, 100, 200, 300), 0, VERDICT_INSIDE, 0);
		add_box(mk_box(-1, -1, -1, 0, 0, 0), 0, VERDICT_INSIDE, 0);

		prev_cfg = 1'b0;
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				if (!prev_cfg) begin
					box_ch.valid <= 1'b0;
					settle();
				end
				cfg_write(row.idx, row.data);
			end else begin
				send_box(row.b, row.typed, row.want);
			end
			prev_cfg = row.is_cfg;
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			box_ch.valid <= 1'b0;
			settle();
			full_rate = (ph % 4 == 3);
			for (int r = 0; r < PLANE_REGS; r++) begin
				if (ph == 0) begin
					cfg_write(plane_reg_e'(r), '0);
				end else if (ph == 1) begin
					cfg_write(plane_reg_e'(r), 64'hFFFF_FFFF_FFFF_FFFF);
				end else begin
					cfg_write(plane_reg_e'(r), rand_plane());
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
					{$urandom, $urandom});
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_box(rand_box(), 1'b0, '0);
			end
		end

		box_ch.valid <= 1'b0;
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (verdict_q.size() != 0) begin
			note_mismatch("missing item", verdict_q.pop_front(), '0);
		end
		if (mismatches == 0) begin
			$display("aabb_frustum_classifier_core regression: pass");
		end else begin
			$display("aabb_frustum_classifier_core regression: fail");
		end
		$finish;
	end

endmodule
